@@ src/rgb_median_filter_2d_defines.svh @@
// ---------------------------------------------------------------------------
// rgb_median_filter_2d_defines
// Assertion macros shared by the median filter checker.
// ---------------------------------------------------------------------------
`ifndef RGB_MEDIAN_FILTER_2D_DEFINES_SVH
`define RGB_MEDIAN_FILTER_2D_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RMF_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmf check failed");

// next-cycle implication
`define RMF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmf check failed");

`endif

@@ src/rmf_pkg.sv @@
// ---------------------------------------------------------------------------
// rmf_pkg
// Shared constants, types and helpers of the RGB median filter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmf_pkg;

  localparam int WIN            = 5;
  localparam int HALF           = WIN / 2;
  localparam int TAPS           = WIN * WIN;
  localparam int ROW_BITS       = $clog2(WIN + 3);
  localparam int RING           = 1 << ROW_BITS;
  localparam int SEL_W          = $clog2(WIN);
  localparam int PRE_W          = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int PIX_W          = 24;
  localparam int CH_W           = 8;
  localparam int POS_W          = 10;
  localparam int CFG_W          = 11;
  localparam int IDX_W          = 2;
  localparam int MIR_W          = 14;
  localparam int QDEPTH         = 4;
  localparam int RESET_DIM      = 512;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  typedef enum logic [IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FK_NONE,
    FK_SHIFT,
    FK_RELOAD,
    FK_PRE
  } fetch_kind_t;

  typedef logic [WIN-1:0][PIX_W-1:0] rmf_column_t;

  typedef struct packed {
    logic                      emit;
    fetch_kind_t               kind;
    logic [PRE_W-1:0]          pre_idx;
    logic [WIN-1:0][SEL_W-1:0] tap_sel;
    logic [POS_W-1:0]          row;
    logic [POS_W-1:0]          col;
    logic                      done;
  } rmf_meta_t;

  typedef struct packed {
    rmf_meta_t   meta;
    rmf_column_t pix;
  } rmf_entry_t;

  // reflect-101 about the edges, clamped for tiny frames
  function automatic logic [MIR_W-1:0] mirror(input logic signed [MIR_W:0] v,
                                               input logic [MIR_W-1:0] n);
    logic signed [MIR_W+1:0] t;
    logic signed [MIR_W+1:0] nn;
    nn = signed'({2'b00, n});
    t  = (MIR_W + 2)'(v);
    if (t < 0) begin
      t = -t;
    end else if (t >= nn) begin
      t = (nn - 1) + (nn - 1) - t;
    end
    if (t < 0) begin
      t = '0;
    end
    if (t > nn - 1) begin
      t = nn - 1;
    end
    return t[MIR_W-1:0];
  endfunction

endpackage

@@ src/rmf_fifo.sv @@
// ---------------------------------------------------------------------------
// rmf_fifo
// Short request queue between the fetch front end and the median back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmf_fifo #(
  parameter int DEPTH = rmf_pkg::QDEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  rmf_pkg::rmf_entry_t        din,
  input  logic                       pop,
  output rmf_pkg::rmf_entry_t        dout,
  output logic                       valid,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import rmf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  rmf_entry_t                 store_r [DEPTH];
  logic [PTR_W-1:0]           wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]           rd_ptr_r, rd_ptr_nxt;
  logic [$clog2(DEPTH+1)-1:0] count_r, count_nxt;
  logic                       do_pop;

  assign valid  = (count_r != '0);
  assign do_pop = pop && valid;
  assign dout   = store_r[rd_ptr_r];
  assign count  = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (int'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (int'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= din;
    end
  end

endmodule

@@ src/rmf_front.sv @@
// ---------------------------------------------------------------------------
// rmf_front
// Takes pixels and drain steps, writes the line store, tracks positions and
// fetches one mirrored window column per request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmf_front #(
  parameter int MAX_WIDTH  = rmf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rmf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [rmf_pkg::IDX_W-1:0]           cfg_index,
  input  logic [rmf_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_cmd,
  input  logic [rmf_pkg::PIX_W-1:0]           in_pix,
  input  logic [$clog2(rmf_pkg::QDEPTH+1)-1:0] q_count,
  output logic                                push,
  output rmf_pkg::rmf_entry_t                 push_entry
);
  import rmf_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROWC_W = $clog2(MAX_HEIGHT + 1);
  localparam int OR_W   = $clog2(MAX_HEIGHT);
  localparam int WD_W   = $clog2(MAX_WIDTH + 1);
  localparam int HT_W   = $clog2(MAX_HEIGHT + 1);
  localparam int LAG_W  = $clog2(HALF * MAX_WIDTH + HALF + 1);
  localparam int RST_W  = (RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : RESET_DIM;
  localparam int RST_H  = (RESET_DIM > MAX_HEIGHT) ? MAX_HEIGHT : RESET_DIM;

  logic [WD_W-1:0]   w_r;
  logic [HT_W-1:0]   h_r;
  logic [LAG_W-1:0]  lag_r;
  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [ROWC_W-1:0] in_row_r, in_row_nxt;
  logic [LAG_W-1:0]  pcnt_r, pcnt_nxt;
  logic [OR_W-1:0]   orow_r, orow_nxt;
  logic [COL_W-1:0]  ocol_r, ocol_nxt;

  logic                           acc;
  logic                           cfg_hit;
  int                             cfg_w, cfg_h;
  logic                           wr_en;
  logic [ROW_BITS-1:0]            wr_bank;
  logic [COL_W-1:0]               wr_col;
  rmf_meta_t                      meta_d;
  logic [WIN-1:0][ROW_BITS-1:0]   bank_d;
  logic [COL_W-1:0]               fcol_d;
  logic                           enq_d;

  logic                           s1_v_r, s2_v_r;
  rmf_meta_t                      s1_meta_r, s2_meta_r;
  logic [WIN-1:0][ROW_BITS-1:0]   s1_bank_r, s2_bank_r;
  logic [COL_W-1:0]               s1_col_r;
  logic [PIX_W-1:0]               rd_r [RING];
  logic [PIX_W-1:0]               mem [RING][MAX_WIDTH];

  assign acc      = in_valid && in_ready;
  assign in_ready = (int'(q_count) + int'(s1_v_r) + int'(s2_v_r)) < QDEPTH;

  always_comb begin
    cfg_hit = 1'b0;
    unique case (cfg_reg_t'(cfg_index))
      REG_FRAME_WIDTH:  cfg_hit = cfg_valid;
      REG_FRAME_HEIGHT: cfg_hit = cfg_valid;
      default:          cfg_hit = 1'b0;
    endcase
    cfg_w = int'(cfg_data);
    if (cfg_w < 3) begin
      cfg_w = 3;
    end else if (cfg_w > MAX_WIDTH) begin
      cfg_w = MAX_WIDTH;
    end
    cfg_h = int'(cfg_data);
    if (cfg_h < 3) begin
      cfg_h = 3;
    end else if (cfg_h > MAX_HEIGHT) begin
      cfg_h = MAX_HEIGHT;
    end
  end

  always_comb begin
    int   wi, hi, lagi, rowi, coli, pci, ri, ci, fpos, rset, xi;
    logic rst_d, emit, prev, done;
    wi   = int'(w_r);
    hi   = int'(h_r);
    lagi = int'(lag_r);
    rst_d = !in_cmd && (int'(in_row_r) >= hi || int'(in_col_r) >= wi);
    rowi = rst_d ? 0 : int'(in_row_r);
    coli = rst_d ? 0 : int'(in_col_r);
    pci  = rst_d ? 0 : int'(pcnt_r);
    ri   = rst_d ? 0 : int'(orow_r);
    ci   = rst_d ? 0 : int'(ocol_r);
    if (!in_cmd) begin
      emit = pci >= lagi;
      prev = !emit && (pci + HALF >= lagi);
    end else begin
      emit = (int'(in_row_r) >= hi) && (int'(orow_r) < hi);
      prev = 1'b0;
    end
    done = emit && (ri == hi - 1) && (ci == wi - 1);

    meta_d         = '0;
    meta_d.emit    = emit;
    meta_d.row     = POS_W'(ri);
    meta_d.col     = POS_W'(ci);
    meta_d.done    = done;
    fcol_d         = '0;
    rset           = 0;
    if (emit) begin
      if (ci <= wi - 1 - HALF) begin
        meta_d.kind = (ci == 0) ? FK_RELOAD : FK_SHIFT;
        fcol_d      = COL_W'(ci + HALF);
        rset        = ri;
      end else if (ri < hi - 1) begin
        meta_d.kind    = FK_PRE;
        meta_d.pre_idx = PRE_W'(ci - (wi - HALF));
        fcol_d         = COL_W'(ci - (wi - HALF));
        rset           = ri + 1;
      end else begin
        meta_d.kind = FK_NONE;
      end
    end else if (prev) begin
      meta_d.kind    = FK_PRE;
      meta_d.pre_idx = PRE_W'(pci + HALF - lagi);
      fcol_d         = COL_W'(pci + HALF - lagi);
      rset           = 0;
    end else begin
      meta_d.kind = FK_NONE;
    end

    fpos = (ci <= wi - 1 - HALF) ? ci + HALF : wi - 1;
    for (int g = 0; g < WIN; g++) begin
      xi = int'(mirror((MIR_W + 1)'(ci + g - HALF), MIR_W'(wi)));
      meta_d.tap_sel[g] = SEL_W'(fpos - xi);
    end
    for (int k = 0; k < WIN; k++) begin
      bank_d[k] = ROW_BITS'(mirror((MIR_W + 1)'(rset + k - HALF), MIR_W'(hi)));
    end
    enq_d = acc && (emit || meta_d.kind != FK_NONE);

    wr_en   = acc && !in_cmd;
    wr_bank = ROW_BITS'(rowi);
    wr_col  = COL_W'(coli);

    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    pcnt_nxt   = pcnt_r;
    orow_nxt   = orow_r;
    ocol_nxt   = ocol_r;
    if (acc) begin
      if (!in_cmd) begin
        if (coli + 1 >= wi) begin
          in_col_nxt = '0;
          in_row_nxt = ROWC_W'(rowi + 1);
        end else begin
          in_col_nxt = COL_W'(coli + 1);
          in_row_nxt = ROWC_W'(rowi);
        end
        pcnt_nxt = emit ? LAG_W'(pci) : LAG_W'(pci + 1);
        orow_nxt = OR_W'(ri);
        ocol_nxt = COL_W'(ci);
      end
      if (emit) begin
        if (done) begin
          in_col_nxt = '0;
          in_row_nxt = '0;
          pcnt_nxt   = '0;
          orow_nxt   = '0;
          ocol_nxt   = '0;
        end else if (ci + 1 >= wi) begin
          ocol_nxt = '0;
          orow_nxt = OR_W'(ri + 1);
        end else begin
          ocol_nxt = COL_W'(ci + 1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r      <= WD_W'(RST_W);
      h_r      <= HT_W'(RST_H);
      lag_r    <= LAG_W'(HALF * RST_W + HALF);
      in_col_r <= '0;
      in_row_r <= '0;
      pcnt_r   <= '0;
      orow_r   <= '0;
      ocol_r   <= '0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
    end else begin
      s1_v_r <= enq_d;
      s2_v_r <= s1_v_r;
      if (cfg_hit) begin
        if (cfg_reg_t'(cfg_index) == REG_FRAME_WIDTH) begin
          w_r   <= WD_W'(cfg_w);
          lag_r <= LAG_W'(HALF * cfg_w + HALF);
        end else begin
          h_r <= HT_W'(cfg_h);
        end
        in_col_r <= '0;
        in_row_r <= '0;
        pcnt_r   <= '0;
        orow_r   <= '0;
        ocol_r   <= '0;
      end else begin
        in_col_r <= in_col_nxt;
        in_row_r <= in_row_nxt;
        pcnt_r   <= pcnt_nxt;
        orow_r   <= orow_nxt;
        ocol_r   <= ocol_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_meta_r <= meta_d;
    s1_bank_r <= bank_d;
    s1_col_r  <= fcol_d;
    s2_meta_r <= s1_meta_r;
    s2_bank_r <= s1_bank_r;
  end

  // line store: one bank per ring row, read in the cycle after the write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_bank][wr_col] <= in_pix;
    end
    if (s1_v_r) begin
      for (int b = 0; b < RING; b++) begin
        rd_r[b] <= mem[b][s1_col_r];
      end
    end
  end

  always_comb begin
    push            = s2_v_r;
    push_entry.meta = s2_meta_r;
    for (int k = 0; k < WIN; k++) begin
      push_entry.pix[k] = rd_r[s2_bank_r[k]];
    end
  end

endmodule

@@ src/rmf_back.sv @@
// ---------------------------------------------------------------------------
// rmf_back
// Column window, prefetch columns and a pipelined odd-even transposition
// sort per colour channel; registered result stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmf_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  rmf_pkg::rmf_entry_t         q_entry,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rmf_pkg::CH_W-1:0]    out_blue,
  output logic [rmf_pkg::CH_W-1:0]    out_green,
  output logic [rmf_pkg::CH_W-1:0]    out_red,
  output logic [rmf_pkg::POS_W-1:0]   out_row,
  output logic [rmf_pkg::POS_W-1:0]   out_col,
  output logic                        out_done
);
  import rmf_pkg::*;

  typedef logic [TAPS-1:0][CH_W-1:0] chan_vec_t;
  typedef chan_vec_t [2:0]           rgb_vec_t;

  rmf_column_t [WIN-1:0]  cols_r, cols_nxt;
  rmf_column_t [HALF-1:0] pre_r, pre_nxt;
  rgb_vec_t               win_d;
  rgb_vec_t               st_r   [TAPS+1];
  logic [POS_W-1:0]       row_r  [TAPS+1];
  logic [POS_W-1:0]       col_r  [TAPS+1];
  logic [TAPS:0]          done_r;
  logic [TAPS:0]          v_r;
  logic                   adv;

  function automatic chan_vec_t cx_layer(input chan_vec_t a, input int odd);
    chan_vec_t b;
    b = a;
    for (int j = 0; j < TAPS - 1; j++) begin
      if ((j % 2) == odd && a[j] > a[j+1]) begin
        b[j]   = a[j+1];
        b[j+1] = a[j];
      end
    end
    return b;
  endfunction

  assign adv   = !v_r[TAPS] || out_ready;
  assign q_pop = q_valid && adv;

  always_comb begin
    cols_nxt = cols_r;
    pre_nxt  = pre_r;
    case (q_entry.meta.kind)
      FK_SHIFT: cols_nxt = {cols_r[WIN-2:0], q_entry.pix};
      FK_RELOAD: begin
        cols_nxt[0] = q_entry.pix;
        for (int i = 1; i <= HALF; i++) begin
          cols_nxt[i] = pre_r[HALF-i];
        end
      end
      FK_PRE:   pre_nxt[q_entry.meta.pre_idx] = q_entry.pix;
      default:  cols_nxt = cols_r;
    endcase
    for (int k = 0; k < WIN; k++) begin
      for (int g = 0; g < WIN; g++) begin
        for (int ch = 0; ch < 3; ch++) begin
          win_d[ch][k*WIN+g] = cols_nxt[q_entry.meta.tap_sel[g]][k][ch*CH_W +: CH_W];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[TAPS-1:0], q_pop && q_entry.meta.emit};
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cols_r <= cols_nxt;
      pre_r  <= pre_nxt;
    end
    if (adv) begin
      st_r[0]   <= win_d;
      row_r[0]  <= q_entry.meta.row;
      col_r[0]  <= q_entry.meta.col;
      done_r[0] <= q_entry.meta.done;
      for (int i = 0; i < TAPS; i++) begin
        for (int ch = 0; ch < 3; ch++) begin
          st_r[i+1][ch] <= cx_layer(st_r[i][ch], i % 2);
        end
        row_r[i+1]  <= row_r[i];
        col_r[i+1]  <= col_r[i];
        done_r[i+1] <= done_r[i];
      end
    end
  end

  assign out_valid = v_r[TAPS];
  assign out_blue  = st_r[TAPS][0][TAPS/2];
  assign out_green = st_r[TAPS][1][TAPS/2];
  assign out_red   = st_r[TAPS][2][TAPS/2];
  assign out_row   = row_r[TAPS];
  assign out_col   = col_r[TAPS];
  assign out_done  = done_r[TAPS];

endmodule

@@ src/rgb_median_filter_2d.sv @@
// ---------------------------------------------------------------------------
// rgb_median_filter_2d
// Streaming per-channel 5x5 median filter with reflect-101 borders.
// ---------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  cfg_     in   cfg_valid/ready    cfg_index, cfg_data (always ready)
//  in_      in   in_tvalid/tready   tdata = pixel, tuser = drain command
//  out_     out  out_tvalid/tready  tdata = medians + position, tuser = frame done
//
//  One request per clock sustained while the result side does not stall; path: 2 fetch
//  stages, queue, window stage, 25 compare-exchange stages.
//  in_tready follows queue credit: drops only when the result side stalls.
//  rst_n is synchronous; the line store needs no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_median_filter_2d #(
  parameter int MAX_WIDTH  = rmf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rmf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [rmf_pkg::IDX_W-1:0] cfg_index,
  input  logic [rmf_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [23:0]               in_tdata,   // blue_in, green_in, red_in
  input  logic                      in_tuser,   // cmd
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [47:0]               out_tdata,  // blue, green, red, out_row, out_col
  output logic                      out_tuser,  // frame_done
  output logic                      out_tlast   // last
);
  import rmf_pkg::*;

  logic                        push, pop, q_valid;
  rmf_entry_t                  push_entry, q_entry;
  logic [$clog2(QDEPTH+1)-1:0] q_count;
  logic [CH_W-1:0]             blue, green, red;
  logic [POS_W-1:0]            row, col;
  logic                        done;

  assign cfg_ready = 1'b1;

  rmf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_cmd     (in_tuser),
    .in_pix     (in_tdata),
    .q_count    (q_count),
    .push       (push),
    .push_entry (push_entry)
  );

  rmf_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (push_entry),
    .pop   (pop),
    .dout  (q_entry),
    .valid (q_valid),
    .count (q_count)
  );

  rmf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_blue  (blue),
    .out_green (green),
    .out_red   (red),
    .out_row   (row),
    .out_col   (col),
    .out_done  (done)
  );

  assign out_tdata = {4'b0000, col, row, red, green, blue};
  assign out_tuser = done;
  assign out_tlast = 1'b1;

endmodule

@@ src/rmf_checker.sv @@
// ---------------------------------------------------------------------------
// rmf_checker
// Port-level checks of the median filter, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rgb_median_filter_2d_defines.svh"

module rmf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  `RMF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `RMF_ASSERT_IMPLY(a_single_result, out_tvalid, out_tlast)
  `RMF_ASSERT_IMPLY(a_reset_idle, $rose(rst_n), !out_tvalid && in_tready)
  `RMF_ASSERT_IMPLY(a_out_known, out_tvalid, !$isunknown({out_tdata, out_tuser, out_tlast}))

endmodule

bind rgb_median_filter_2d rmf_checker u_rmf_checker (.*);

@@ dv/rgb_median_filter_2d_tb.sv @@
// ---------------------------------------------------------------------------
// rgb_median_filter_2d_tb
// Self-checking bench for the streaming RGB 5x5 median filter: a clocked
// driver feeds queued pixel/drain requests, a clocked monitor compares each
// result against a software model of the windowed median with reflect-101
// borders, and register writes sweep the frame sizes between phases.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_median_filter_2d_tb;
  import rmf_pkg::*;

  localparam int LINE_MAX = 1024;
  localparam int NROWS = 6;
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd2;
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct {
    logic       cmd;
    logic [7:0] b, g, r;
  } px_req_t;

  typedef struct {
    logic [7:0] b, g, r;
    logic [9:0] row, col;
    logic       done, last;
  } med_res_t;

  logic clk = 0, rst_n = 0;
  logic cfg_valid = 0, cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_tvalid = 0, in_tready;
  logic [23:0] in_tdata = '0;
  logic in_tuser = 0;
  logic out_tvalid, out_tready = 0;
  logic [47:0] out_tdata;
  logic out_tuser, out_tlast;

  rgb_median_filter_2d uut (.*);

  initial forever #2 clk = ~clk;

  px_req_t  req_q[$];
  med_res_t median_q[$];
  int errors = 0;
  int sent = 0;
  bit idle_on = 1;
  int hold_req = 0;

  // model state
  logic [23:0] lines[NROWS*LINE_MAX];
  int m_w = RESET_DIM, m_h = RESET_DIM;
  int m_col, m_row, m_orow, m_ocol;

  function automatic int reflect(int v, int n);
    if (v < 0) v = -v;
    else if (v >= n) v = 2 * (n - 1) - v;
    if (v < 0) v = 0;
    if (v > n - 1) v = n - 1;
    return v;
  endfunction

  function automatic logic [7:0] median_of(logic [7:0] a[TAPS]);
    logic [7:0] t;
    for (int i = 0; i < TAPS; i++)
      for (int j = 0; j < TAPS - 1 - i; j++)
        if (a[j] > a[j+1]) begin
          t = a[j]; a[j] = a[j+1]; a[j+1] = t;
        end
    return a[TAPS/2];
  endfunction

  function automatic int clip(int v, int hi);
    return v < 3 ? 3 : (v > hi ? hi : v);
  endfunction

  task automatic emit_median(int w, int h);
    logic [7:0] cb[TAPS], cg[TAPS], cr[TAPS];
    logic [23:0] p;
    med_res_t e;
    int n, y, x;
    n = 0;
    for (int k = 0; k < WIN; k++) begin
      y = reflect(m_orow + k - HALF, h);
      for (int g = 0; g < WIN; g++) begin
        x = reflect(m_ocol + g - HALF, w);
        p = lines[(y % NROWS) * LINE_MAX + x];
        cb[n] = p[7:0]; cg[n] = p[15:8]; cr[n] = p[23:16];
        n++;
      end
    end
    e.b = median_of(cb); e.g = median_of(cg); e.r = median_of(cr);
    e.row = m_orow[9:0]; e.col = m_ocol[9:0];
    e.done = (m_orow == h - 1) && (m_ocol == w - 1);
    e.last = 1'b1;
    median_q.push_back(e);
    if (e.done) begin
      m_col = 0; m_row = 0; m_orow = 0; m_ocol = 0;
    end else if (++m_ocol >= w) begin
      m_ocol = 0; m_orow++;
    end
  endtask

  task automatic predict(logic cmd, logic [23:0] pix);
    int w, h, pos;
    w = clip(m_w, LINE_MAX);
    h = clip(m_h, LINE_MAX);
    if (cmd == CMD_PIXEL) begin
      if (m_row >= h || m_col >= w) begin
        m_col = 0; m_row = 0; m_orow = 0; m_ocol = 0;
      end
      lines[(m_row % NROWS) * LINE_MAX + m_col] = pix;
      pos = m_row * w + m_col;
      if (++m_col >= w) begin
        m_col = 0; m_row++;
      end
      if (pos >= HALF * w + HALF) emit_median(w, h);
    end else if (m_row >= h && m_orow < h) begin
      emit_median(w, h);
    end
  endtask

  // driver
  int gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
    end else begin
      if (in_tvalid && in_tready) predict(in_tuser, in_tdata);
      if (!(in_tvalid && !in_tready)) begin
        if (gap > 0) begin
          gap--;
          in_tvalid <= 0;
        end else if (req_q.size() > 0) begin
          px_req_t q;
          q = req_q.pop_front();
          in_tvalid <= 1;
          in_tuser <= q.cmd;
          in_tdata <= {q.r, q.g, q.b};
          gap = idle_on ? $urandom_range(0, 7) : 0;
        end else begin
          in_tvalid <= 0;
        end
      end
    end
  end

  // config writes applied to the model
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      if (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT) begin
        if (cfg_index == REG_FRAME_WIDTH) m_w = cfg_data;
        else m_h = cfg_data;
        m_col = 0; m_row = 0; m_orow = 0; m_ocol = 0;
      end
    end
  end

  // result side: ready/stall and check
  int stall = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        med_res_t e;
        if (median_q.size() == 0) begin
          $error("unexpected result tdata=%h", out_tdata);
          errors++;
        end else begin
          e = median_q.pop_front();
          if (out_tdata[7:0] !== e.b) begin
            $error("blue_median exp %0d got %0d", e.b, out_tdata[7:0]); errors++;
          end
          if (out_tdata[15:8] !== e.g) begin
            $error("green_median exp %0d got %0d", e.g, out_tdata[15:8]); errors++;
          end
          if (out_tdata[23:16] !== e.r) begin
            $error("red_median exp %0d got %0d", e.r, out_tdata[23:16]); errors++;
          end
          if (out_tdata[33:24] !== e.row) begin
            $error("out_row exp %0d got %0d", e.row, out_tdata[33:24]); errors++;
          end
          if (out_tdata[43:34] !== e.col) begin
            $error("out_col exp %0d got %0d", e.col, out_tdata[43:34]); errors++;
          end
          if (out_tuser !== e.done) begin
            $error("frame_done exp %0d got %0d", e.done, out_tuser); errors++;
          end
          if (out_tlast !== e.last) begin
            $error("last exp %0d got %0d", e.last, out_tlast); errors++;
          end
        end
        stall = idle_on ? $urandom_range(0, 7) : 0;
      end
      if (hold_req > 0) begin
        hold_req--;
        out_tready <= 0;
      end else if (stall > 0) begin
        stall--;
        out_tready <= 0;
      end else begin
        out_tready <= 1;
      end
    end
  end

  task automatic settle();
    do @(posedge clk);
    while (req_q.size() != 0 || in_tvalid || median_q.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, int val);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic set_size(int w, int h);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  function automatic logic [7:0] chan();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push(logic cmd);
    px_req_t q;
    q.cmd = cmd; q.b = chan(); q.g = chan(); q.r = chan();
    req_q.push_back(q);
    sent++;
  endtask

  task automatic push_frame(int w, int h, int npix, int ndrain);
    for (int i = 0; i < npix; i++) push(CMD_PIXEL);
    for (int i = 0; i < ndrain; i++) push(CMD_DRAIN);
  endtask

  initial begin
    int w, h, mode, k;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: smallest frame, early and late drains, restart on new pixel
    set_size(3, 3);
    push(CMD_DRAIN);
    push_frame(3, 3, 9, 8);
    push(CMD_DRAIN);
    push_frame(3, 3, 9, 3);
    push_frame(3, 3, 2, 0);
    settle();
    write_reg(REG_SPARE, 5);
    push_frame(3, 3, 7, 0);
    settle();
    // register write drops the frame in progress
    write_reg(REG_FRAME_WIDTH, 4);
    push_frame(4, 3, 12, 10);
    settle();

    // random frames
    while (sent < 70) begin
      w = $urandom_range(3, 5);
      h = $urandom_range(3, 4);
      set_size(w, h);
      mode = $urandom_range(0, 7);
      case (mode)
        0: push_frame(w, h, $urandom_range(1, w * h - 1), $urandom_range(0, 2));
        1: begin
          push_frame(w, h, w * h, $urandom_range(0, 2 * w + 1));
          push_frame(w, h, w * h, 2 * w + 2);
        end
        2: begin
          k = $urandom_range(1, w * h - 1);
          push_frame(w, h, k, 0);
          settle();
          push_frame(w, h, w * h - k, 2 * w + 4);
        end
        default: push_frame(w, h, w * h, 2 * w + 2 + $urandom_range(0, 2));
      endcase
      settle();
    end

    // clamped sizes; long receiver hold while the sender keeps going
    set_size(0, 2047);
    hold_req = 300;
    push_frame(3, 1024, 42, 2);
    settle();
    set_size(2047, 0);
    push_frame(1024, 3, 6, 0);
    settle();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
